/* hw/rtl/tjf_pkg.sv */
// Package for the touch jitter filter: request types, register codes and helpers.
`default_nettype none

package tjf_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned LAND_W  = 16;
    localparam int unsigned THR_W   = 12;
    localparam int unsigned SQ_W    = 2 * COORD_W;
    localparam int unsigned DIST_W  = SQ_W + 1;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_TICKS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANDING_THRESHOLD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAYING_THRESHOLD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_THRESHOLD  = 4'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               touching;
        logic [TICK_W-1:0]  now_tick;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0]  out_slot;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               out_touching;
    } t_out;

    // Register file as seen by the datapath: thresholds kept squared.
    typedef struct packed {
        logic [LAND_W-1:0] landing_ticks;
        logic [SQ_W-1:0]   land_sq;
        logic [SQ_W-1:0]   stay_sq;
        logic [SQ_W-1:0]   move_sq;
    } t_cfg;

    // Tracker entry read for the slot in the first stage.
    typedef struct packed {
        logic [COORD_W-1:0] held_x;
        logic [COORD_W-1:0] held_y;
        logic [TICK_W-1:0]  touch_start;
    } t_rd;

    // Request in the commit stage, as a possible new tracker value.
    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [TICK_W-1:0]  now_tick;
    } t_byp;

    // Precomputed distances and window flags, against the stored entry
    // and against the request ahead.
    typedef struct packed {
        t_in               item;
        logic [DIST_W-1:0] dist_st;
        logic [DIST_W-1:0] dist_bp;
        logic              win_st;
        logic              win_bp;
    } t_pre;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/touch_jitter_filter_unit.sv */
// Top level of the touch jitter filter: per-slot contact position smoothing.
//
// Each request carries one contact slot sample (slot, position, touching
// flag, free-running tick) and yields exactly one result, one request per
// cycle sustained while the sink does not stall, including back-to-back
// requests to the same slot. Stage one registers
// the request and folds the landing length into the tick; stage two
// computes the squared distances and the landing window test, both against
// the stored tracker entry and against the request now committing; stage
// three picks the threshold, compares, updates the tracker and fills the
// output register. A release clears the slot's active flag and passes the
// raw position through; slots at or above SLOTS pass through and change
// nothing. Trackers live in flip-flops and reset clears their active flags
// at once, so no request waits after reset. Write the configuration
// registers (index 0 landing ticks, 1 landing threshold, 2 staying
// threshold, 3 moving threshold; other indexes ignored) only while no
// request is in flight; a threshold takes effect the next cycle.
`default_nettype none

module touch_jitter_filter_unit #(
    parameter int unsigned SLOTS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire tjf_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output tjf_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tjf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tjf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tjf_pkg::t_cfg              cfg;
    tjf_pkg::t_rd               rd;
    tjf_pkg::t_byp              byp;
    tjf_pkg::t_pre              pre;
    logic                       pre_valid;
    logic                       adv_b;
    logic [tjf_pkg::SLOT_W-1:0] rd_slot;

    tjf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Capture requests and precompute distances for the commit stage.
    tjf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_adv_b     (adv_b),
        .o_rd_slot   (rd_slot),
        .i_rd        (rd),
        .i_byp       (byp),
        .o_pre_valid (pre_valid),
        .o_pre       (pre)
    );

    // Decide, update the slot tracker and hold the result for the sink.
    tjf_track #(
        .SLOTS (SLOTS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pre_valid (pre_valid),
        .i_pre       (pre),
        .o_adv_b     (adv_b),
        .i_rd_slot   (rd_slot),
        .o_rd        (rd),
        .o_byp       (byp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // An accepted request always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> pre_valid)
        else $error("accepted request missing from first stage");

    // Backpressure only when every stage is full and the sink stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (pre_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // A held first stage keeps its request while stalled.
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (pre_valid && $stable(pre.item)))
        else $error("first stage request changed under stall");

endmodule

`default_nettype wire

/* hw/rtl/tjf_cfg.sv */
// Configuration registers of the touch jitter filter, thresholds stored squared.
`default_nettype none

module tjf_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tjf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tjf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tjf_pkg::t_cfg                        o_cfg
);

    tjf_pkg::t_cfg             r_cfg;
    tjf_pkg::t_cfg             n_cfg;
    logic [tjf_pkg::THR_W-1:0] thr;
    logic [tjf_pkg::SQ_W-1:0]  thr_sq;

    assign o_cfg_ready = 1'b1;
    assign thr         = i_cfg_data[tjf_pkg::THR_W-1:0];
    assign thr_sq      = tjf_pkg::SQ_W'(thr) * tjf_pkg::SQ_W'(thr);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tjf_pkg::CFG_LANDING_TICKS:     n_cfg.landing_ticks = i_cfg_data;
                tjf_pkg::CFG_LANDING_THRESHOLD: n_cfg.land_sq       = thr_sq;
                tjf_pkg::CFG_STAYING_THRESHOLD: n_cfg.stay_sq       = thr_sq;
                tjf_pkg::CFG_MOVING_THRESHOLD:  n_cfg.move_sq       = thr_sq;
                default:                        n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/tjf_front.sv */
// Input stage of the touch jitter filter: capture and distance precompute.
`default_nettype none

module tjf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire tjf_pkg::t_in                i_in_data,
    input  wire tjf_pkg::t_cfg               i_cfg,
    input  wire logic                        i_adv_b,
    output logic [tjf_pkg::SLOT_W-1:0]       o_rd_slot,
    input  wire tjf_pkg::t_rd                i_rd,
    input  wire tjf_pkg::t_byp               i_byp,
    output logic                             o_pre_valid,
    output tjf_pkg::t_pre                    o_pre
);

    logic                       r_a_valid;
    tjf_pkg::t_in               r_a;
    logic [tjf_pkg::TICK_W-1:0] r_a_nml;
    logic                       adv_a;
    logic [tjf_pkg::TICK_W-1:0] diff_st;
    logic [tjf_pkg::TICK_W-1:0] diff_bp;

    assign adv_a      = !r_a_valid || i_adv_b;
    assign o_in_stall = !adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv_a) begin
            r_a_valid <= i_in_valid;
        end
    end

    // Fold the landing length into the tick now, so the window test
    // later needs only one subtract against the landing tick.
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a     <= i_in_data;
            r_a_nml <= i_in_data.now_tick - tjf_pkg::TICK_W'(i_cfg.landing_ticks);
        end
    end

    assign o_rd_slot = r_a.slot;
    assign diff_st   = r_a_nml - i_rd.touch_start;
    assign diff_bp   = r_a_nml - i_byp.now_tick;

    always_comb begin
        o_pre.item    = r_a;
        o_pre.dist_st = tjf_pkg::DIST_W'(tjf_pkg::sq_diff(r_a.pos_x, i_rd.held_x))
                      + tjf_pkg::DIST_W'(tjf_pkg::sq_diff(r_a.pos_y, i_rd.held_y));
        o_pre.dist_bp = tjf_pkg::DIST_W'(tjf_pkg::sq_diff(r_a.pos_x, i_byp.pos_x))
                      + tjf_pkg::DIST_W'(tjf_pkg::sq_diff(r_a.pos_y, i_byp.pos_y));
        o_pre.win_st  = diff_st[tjf_pkg::TICK_W-1];
        o_pre.win_bp  = diff_bp[tjf_pkg::TICK_W-1];
    end

    assign o_pre_valid = r_a_valid;

endmodule

`default_nettype wire

/* hw/rtl/tjf_track.sv */
// Slot trackers, commit decision and output register of the touch jitter filter.
`default_nettype none

module tjf_track #(
    parameter int unsigned SLOTS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tjf_pkg::t_cfg          i_cfg,
    input  wire logic                   i_pre_valid,
    input  wire tjf_pkg::t_pre          i_pre,
    output logic                        o_adv_b,
    input  wire logic [tjf_pkg::SLOT_W-1:0] i_rd_slot,
    output tjf_pkg::t_rd                o_rd,
    output tjf_pkg::t_byp               o_byp,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output tjf_pkg::t_out               o_out_data
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [tjf_pkg::SLOT_W:0] SLOT_LIM = (tjf_pkg::SLOT_W + 1)'(SLOTS);

    logic [tjf_pkg::COORD_W-1:0] r_held_x [SLOTS];
    logic [tjf_pkg::COORD_W-1:0] r_held_y [SLOTS];
    logic [tjf_pkg::TICK_W-1:0]  r_start  [SLOTS];
    logic [SLOTS-1:0]            r_active;
    logic [SLOTS-1:0]            r_moving;

    logic                r_b_valid;
    tjf_pkg::t_pre       r_b;
    logic                r_b_sel_held;
    logic                r_b_sel_start;
    logic                r_c_valid;
    tjf_pkg::t_out       r_c;

    logic                adv_c;
    logic                commit;
    logic                rng_b;
    logic                rng_rd;
    logic [IW-1:0]       idx_b;
    logic [IW-1:0]       idx_rd;
    logic                act;
    logic                mov;
    logic                win;
    logic [tjf_pkg::DIST_W-1:0] dist_sq;
    logic [tjf_pkg::SQ_W-1:0]   thr_sq;
    logic                jitter;
    logic                first;
    logic                follow;
    logic                wr_held;
    logic                wr_start;
    logic                same_slot;
    logic                n_sel_held;
    logic                n_sel_start;
    tjf_pkg::t_out       n_c;

    assign adv_c   = !r_c_valid || !i_out_stall;
    assign o_adv_b = !r_b_valid || adv_c;
    assign commit  = r_b_valid && o_adv_b;

    assign rng_b  = {1'b0, r_b.item.slot} < SLOT_LIM;
    assign rng_rd = {1'b0, i_rd_slot} < SLOT_LIM;
    assign idx_b  = rng_b  ? r_b.item.slot[IW-1:0] : '0;
    assign idx_rd = rng_rd ? i_rd_slot[IW-1:0]     : '0;

    assign o_rd.held_x      = r_held_x[idx_rd];
    assign o_rd.held_y      = r_held_y[idx_rd];
    assign o_rd.touch_start = r_start[idx_rd];

    assign o_byp.pos_x    = r_b.item.pos_x;
    assign o_byp.pos_y    = r_b.item.pos_y;
    assign o_byp.now_tick = r_b.item.now_tick;

    always_comb begin
        act      = r_active[idx_b];
        mov      = r_moving[idx_b];
        win      = r_b_sel_start ? r_b.win_bp  : r_b.win_st;
        dist_sq  = r_b_sel_held  ? r_b.dist_bp : r_b.dist_st;
        thr_sq   = mov ? i_cfg.move_sq : (win ? i_cfg.land_sq : i_cfg.stay_sq);
        jitter   = dist_sq <= tjf_pkg::DIST_W'(thr_sq);
        first    = rng_b && r_b.item.touching && !act;
        follow   = rng_b && r_b.item.touching && act;
        wr_held  = first || (follow && !jitter);
        wr_start = first;

        n_c.out_slot     = r_b.item.slot;
        n_c.out_x        = (follow && jitter) ? r_held_x[idx_b] : r_b.item.pos_x;
        n_c.out_y        = (follow && jitter) ? r_held_y[idx_b] : r_b.item.pos_y;
        n_c.out_touching = r_b.item.touching;

        // The request entering this stage saw the entry before this commit.
        same_slot   = i_pre.item.slot == r_b.item.slot;
        n_sel_held  = r_b_valid && wr_held  && same_slot;
        n_sel_start = r_b_valid && wr_start && same_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_moving <= '0;
        end else if (commit && rng_b) begin
            if (!r_b.item.touching) begin
                r_active[idx_b] <= 1'b0;
            end else if (first) begin
                r_active[idx_b] <= 1'b1;
                r_moving[idx_b] <= 1'b0;
            end else if (!jitter) begin
                r_moving[idx_b] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && wr_held) begin
            r_held_x[idx_b] <= r_b.item.pos_x;
            r_held_y[idx_b] <= r_b.item.pos_y;
        end
        if (commit && wr_start) begin
            r_start[idx_b] <= r_b.item.now_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (o_adv_b) begin
                r_b_valid <= i_pre_valid;
            end
            if (adv_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv_b) begin
            r_b           <= i_pre;
            r_b_sel_held  <= n_sel_held;
            r_b_sel_start <= n_sel_start;
        end
        if (adv_c) begin
            r_c <= n_c;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_data  = r_c;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the touch jitter filter: random traffic, live prediction, scoreboard.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned SLOT_COUNT = 16;

    // ---------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    tjf_pkg::t_in                   i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    tjf_pkg::t_out                  o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [tjf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tjf_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    touch_jitter_filter_unit #(
        .SLOTS (SLOT_COUNT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the filter: registers and per-slot trackers
    // ---------------------------------------------------------------
    logic [tjf_pkg::LAND_W-1:0]  land_ticks = '0;
    logic [tjf_pkg::THR_W-1:0]   land_thr   = '0;
    logic [tjf_pkg::THR_W-1:0]   stay_thr   = '0;
    logic [tjf_pkg::THR_W-1:0]   move_thr   = '0;

    logic [tjf_pkg::COORD_W-1:0] trk_x      [SLOT_COUNT] = '{default: '0};
    logic [tjf_pkg::COORD_W-1:0] trk_y      [SLOT_COUNT] = '{default: '0};
    logic                        trk_live   [SLOT_COUNT] = '{default: 1'b0};
    logic                        trk_moving [SLOT_COUNT] = '{default: 1'b0};
    logic [tjf_pkg::TICK_W-1:0]  trk_start  [SLOT_COUNT] = '{default: '0};

    // Requests waiting for the driver, and filtered reports still owed by the block.
    tjf_pkg::t_in  samples_to_send [$];
    tjf_pkg::t_out filtered_due    [$];

    int mismatches = 0;
    int accepted   = 0;
    int settings   = 0;
    int n_landed   = 0;
    int n_held     = 0;
    int n_moved    = 0;
    int n_lifted   = 0;

    // Chance of starting an idle burst, one in idle_odds; zero turns idling off.
    int idle_odds = 4;

    function automatic logic [31:0] sq_gap(input logic [tjf_pkg::COORD_W-1:0] a,
                                           input logic [tjf_pkg::COORD_W-1:0] b);
        logic [31:0] d;
        d = (a > b) ? 32'(a - b) : 32'(b - a);
        return d * d;
    endfunction

    // Advance the shadow trackers by one request and return the report it must produce.
    function automatic tjf_pkg::t_out filter_contact(input tjf_pkg::t_in smp);
        tjf_pkg::t_out rep;
        logic [31:0]   thr;
        logic [31:0]   gap_sq;
        logic [31:0]   landed;
        logic [31:0]   lag;
        int            s;
        s = int'(smp.slot);
        rep.out_slot     = smp.slot;
        rep.out_x        = smp.pos_x;
        rep.out_y        = smp.pos_y;
        rep.out_touching = smp.touching;
        if (s < SLOT_COUNT) begin
            if (!smp.touching) begin
                trk_live[s] = 1'b0;
                n_lifted++;
            end else if (!trk_live[s]) begin
                trk_x[s]      = smp.pos_x;
                trk_y[s]      = smp.pos_y;
                trk_live[s]   = 1'b1;
                trk_moving[s] = 1'b0;
                trk_start[s]  = smp.now_tick;
                n_landed++;
            end else begin
                if (trk_moving[s]) begin
                    thr = 32'(move_thr);
                end else begin
                    // Window is open while now comes before start + length, mod 2^32.
                    landed = trk_start[s] + 32'(land_ticks);
                    lag    = smp.now_tick - landed;
                    thr    = lag[31] ? 32'(land_thr) : 32'(stay_thr);
                end
                gap_sq = sq_gap(smp.pos_x, trk_x[s]) + sq_gap(smp.pos_y, trk_y[s]);
                if (gap_sq <= thr * thr) begin
                    rep.out_x = trk_x[s];
                    rep.out_y = trk_y[s];
                    n_held++;
                end else begin
                    trk_x[s]      = smp.pos_x;
                    trk_y[s]      = smp.pos_y;
                    trk_moving[s] = 1'b1;
                    n_moved++;
                end
            end
        end
        return rep;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: predict on every accepted request, then pick the next
    // request or an idle burst. A stalled request holds its payload.
    // ---------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            filtered_due.push_back(filter_contact(i_in_data));
            accepted++;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (samples_to_send.size() != 0 && idle_odds != 0 &&
                         $urandom_range(1, idle_odds) == 1) begin
                // Start an idle burst, this cycle included.
                gap_left   <= $urandom_range(0, 8);
                i_in_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
                i_in_data  <= samples_to_send.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Report monitor: check each accepted report against the oldest one
    // owed, then decide the stall for the next cycle.
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin : report_check
        tjf_pkg::t_out due;
        if (o_out_valid && !i_out_stall) begin
            if (filtered_due.size() == 0) begin
                $error("report for slot %0d arrived with nothing owed", o_out_data.out_slot);
                mismatches++;
            end else begin
                due = filtered_due.pop_front();
                if (o_out_data.out_slot !== due.out_slot) begin
                    $error("out_slot: expected %0d, got %0d", due.out_slot, o_out_data.out_slot);
                    mismatches++;
                end
                if (o_out_data.out_x !== due.out_x) begin
                    $error("out_x: expected %0d, got %0d", due.out_x, o_out_data.out_x);
                    mismatches++;
                end
                if (o_out_data.out_y !== due.out_y) begin
                    $error("out_y: expected %0d, got %0d", due.out_y, o_out_data.out_y);
                    mismatches++;
                end
                if (o_out_data.out_touching !== due.out_touching) begin
                    $error("out_touching: expected %0d, got %0d",
                           due.out_touching, o_out_data.out_touching);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left  <= $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Write one register; the shadow copy follows at the edge the write lands.
    task automatic write_reg(input logic [tjf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tjf_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tjf_pkg::CFG_LANDING_TICKS:     land_ticks = val;
            tjf_pkg::CFG_LANDING_THRESHOLD: land_thr   = val[tjf_pkg::THR_W-1:0];
            tjf_pkg::CFG_STAYING_THRESHOLD: stay_thr   = val[tjf_pkg::THR_W-1:0];
            tjf_pkg::CFG_MOVING_THRESHOLD:  move_thr   = val[tjf_pkg::THR_W-1:0];
            default: ;
        endcase
    endtask

    // Program all four registers (junk in the unused upper data bits),
    // plus one write to an unused index that must change nothing.
    task automatic program_filter(input logic [tjf_pkg::LAND_W-1:0] ticks,
                                  input logic [tjf_pkg::THR_W-1:0]  lthr,
                                  input logic [tjf_pkg::THR_W-1:0]  sthr,
                                  input logic [tjf_pkg::THR_W-1:0]  mthr);
        write_reg(tjf_pkg::CFG_LANDING_TICKS, ticks);
        write_reg(tjf_pkg::CFG_LANDING_THRESHOLD, {4'($urandom_range(0, 15)), lthr});
        write_reg(tjf_pkg::CFG_STAYING_THRESHOLD, {4'($urandom_range(0, 15)), sthr});
        write_reg(tjf_pkg::CFG_MOVING_THRESHOLD, {4'($urandom_range(0, 15)), mthr});
        write_reg(tjf_pkg::CFG_IDX_W'($urandom_range(int'(tjf_pkg::CFG_MOVING_THRESHOLD) + 1,
                                                     (1 << tjf_pkg::CFG_IDX_W) - 1)),
                  tjf_pkg::CFG_DATA_W'($urandom()));
        settings++;
    endtask

    task automatic send(input int s, input int x, input int y, input bit down,
                        input logic [tjf_pkg::TICK_W-1:0] tick);
        tjf_pkg::t_in smp;
        smp.slot     = tjf_pkg::SLOT_W'(s);
        smp.pos_x    = tjf_pkg::COORD_W'(x);
        smp.pos_y    = tjf_pkg::COORD_W'(y);
        smp.touching = down;
        smp.now_tick = tick;
        samples_to_send.push_back(smp);
    endtask

    // Hold off until the block has delivered everything owed, then let the pipe settle.
    task automatic settle();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || i_in_valid || filtered_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Finger model used by the random traffic.
    logic [tjf_pkg::COORD_W-1:0] pen_x    [SLOT_COUNT] = '{default: '0};
    logic [tjf_pkg::COORD_W-1:0] pen_y    [SLOT_COUNT] = '{default: '0};
    bit                          pen_down [SLOT_COUNT] = '{default: 1'b0};
    logic [tjf_pkg::TICK_W-1:0]  tick_now = '0;

    function automatic logic [tjf_pkg::COORD_W-1:0] nudge(
            input logic [tjf_pkg::COORD_W-1:0] c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return tjf_pkg::COORD_W'(v);
    endfunction

    // Mostly well-formed finger sessions (land, jitter, drift, jump, lift)
    // with some noise mixed in.
    task automatic queue_traffic(input int items, input int slot_hi, input int span_max,
                                 input int tick_step);
        int r;
        int s;
        int k;
        int span;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, slot_hi);
            if (r < 8) begin
                send($urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 4095),
                     1'($urandom_range(0, 1)), $urandom());
            end else if (r < 14) begin
                pen_down[s] = 1'b0;
                send(s, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, tick_now);
            end else begin
                if (!pen_down[s]) begin
                    pen_x[s]    = tjf_pkg::COORD_W'($urandom_range(0, 4095));
                    pen_y[s]    = tjf_pkg::COORD_W'($urandom_range(0, 4095));
                    pen_down[s] = 1'b1;
                end else begin
                    k = $urandom_range(0, 9);
                    span = (k < 4) ? 3 : (k < 8) ? span_max : (k < 9) ? 4 * span_max : 4095;
                    pen_x[s] = nudge(pen_x[s], span);
                    pen_y[s] = nudge(pen_y[s], span);
                end
                send(s, int'(pen_x[s]), int'(pen_y[s]), 1'b1, tick_now);
            end
            tick_now += $urandom_range(0, tick_step);
        end
    endtask

    task automatic run_phase(input logic [tjf_pkg::LAND_W-1:0] ticks,
                             input logic [tjf_pkg::THR_W-1:0] lthr,
                             input logic [tjf_pkg::THR_W-1:0] sthr,
                             input logic [tjf_pkg::THR_W-1:0] mthr,
                             input int items, input int slot_hi, input int span_max,
                             input int tick_step, input int odds,
                             input logic [tjf_pkg::TICK_W-1:0] tick_base);
        program_filter(ticks, lthr, sthr, mthr);
        idle_odds = odds;
        tick_now  = tick_base;
        queue_traffic(items, slot_hi, span_max, tick_step);
        settle();
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: every threshold zero, so only an exact repeat is held.
        send(0, 0, 0, 1'b1, 32'd0);
        send(0, 0, 0, 1'b1, 32'd5);
        send(0, 1, 0, 1'b1, 32'd6);
        send(0, 1, 0, 1'b1, 32'd7);
        send(0, 4095, 4095, 1'b0, 32'd8);
        send(15, 4095, 4095, 1'b1, 32'hFFFF_FFFF);
        send(15, 0, 0, 1'b1, 32'h0000_0000);
        send(7, 4095, 0, 1'b0, 32'h8000_0000);
        settle();

        program_filter(16'd100, 12'd50, 12'd10, 12'd3);
        // Landing window straddles the tick wrap: radius exactly on the
        // landing threshold holds, one step past it moves on the last open tick.
        send(3, 1000, 1000, 1'b1, 32'hFFFF_FFC0);
        send(3, 1030, 1040, 1'b1, 32'h0000_0010);
        send(3, 1031, 1040, 1'b1, 32'h0000_0023);
        // Moving threshold: inside, on the edge, then past it.
        send(3, 1033, 1040, 1'b1, 32'h0000_0024);
        send(3, 1034, 1040, 1'b1, 32'h0000_0025);
        send(3, 1035, 1040, 1'b1, 32'h0000_0026);
        // Window closes exactly at start + length: staying threshold applies.
        send(4, 200, 200, 1'b1, 32'd1000);
        send(4, 206, 208, 1'b1, 32'd1100);
        send(4, 207, 208, 1'b1, 32'd1101);
        // Lift and land again: tracker restarts from the new position.
        send(4, 0, 0, 1'b0, 32'd1200);
        send(4, 0, 0, 1'b1, 32'd1201);
        send(4, 4, 0, 1'b1, 32'd1202);
        settle();

        run_phase(tjf_pkg::LAND_W'($urandom_range(0, 3000)),
                  tjf_pkg::THR_W'($urandom_range(0, 40)), tjf_pkg::THR_W'($urandom_range(0, 40)),
                  tjf_pkg::THR_W'($urandom_range(0, 40)), 260, 15, 48, 40, 4, $urandom());
        // Extremes: longest window, widest radii, ticks running through the wrap.
        run_phase(16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 200, 15, 4095, 600, 6, 32'hFFFF_F000);
        // All zero, and no idling on either side for a stretch.
        run_phase(16'h0000, 12'h000, 12'h000, 12'h000, 200, 7, 8, 40, 0, $urandom());
        // Few slots, so the same slot comes back to back.
        run_phase(tjf_pkg::LAND_W'($urandom_range(0, 50)),
                  tjf_pkg::THR_W'($urandom_range(0, 30)), tjf_pkg::THR_W'($urandom_range(0, 30)),
                  tjf_pkg::THR_W'($urandom_range(0, 30)), 300, 2, 36, 8, 3, $urandom());
        run_phase(tjf_pkg::LAND_W'($urandom_range(0, 65535)),
                  tjf_pkg::THR_W'($urandom_range(0, 200)),
                  tjf_pkg::THR_W'($urandom_range(0, 200)),
                  tjf_pkg::THR_W'($urandom_range(0, 200)), 250, 15, 150, 300, 5, $urandom());
        // Closing part at full rate.
        run_phase(tjf_pkg::LAND_W'($urandom_range(0, 2000)),
                  tjf_pkg::THR_W'($urandom_range(0, 60)), tjf_pkg::THR_W'($urandom_range(0, 60)),
                  tjf_pkg::THR_W'($urandom_range(0, 60)), 240, 15, 64, 40, 0, $urandom());

        repeat (8) @(posedge i_clk);
        $display("Ran %0d contact requests under %0d register settings, ticks wrapping.",
                 accepted, settings);
        $display("Landings %0d, jitter held %0d, moves %0d, lifts %0d.",
                 n_landed, n_held, n_moved, n_lifted);
        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout with %0d reports still owed", filtered_due.size());
        $display("FAIL");
        $finish;
    end

endmodule
